>>> hw/rtl/adcsup_pkg.sv
// Shared types, constants and lookup functions of the ADC scan and rail supervisor.
package adcsup_pkg;

	typedef logic [2:0] chan_t;

	localparam logic [3:0] NO_CHANNEL   = 4'd8;
	localparam chan_t      CH_POS_FIRST = 3'd4;
	localparam chan_t      CH_POS_LAST  = 3'd6;
	localparam chan_t      CH_RAIL_HIGH = 3'd1;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_RAIL = 2'd1,
		KIND_POS  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_NOM_STD     = 3'd0,
		REG_NOM_HIGH    = 3'd1,
		REG_WIN_STD     = 3'd2,
		REG_WIN_HIGH    = 3'd3,
		REG_ERR_LIMIT   = 3'd4,
		REG_SCAN_PERIOD = 3'd5
	} cfg_reg_t;

	localparam logic [11:0] NOM_STD_RST     = 12'd3072;
	localparam logic [11:0] NOM_HIGH_RST    = 12'd3277;
	localparam logic [11:0] WIN_STD_RST     = 12'd307;
	localparam logic [11:0] WIN_HIGH_RST    = 12'd328;
	localparam logic [3:0]  ERR_LIMIT_RST   = 4'd3;
	localparam logic [15:0] SCAN_PERIOD_RST = 16'd5000;

	// rail check settings handed to the checker
	typedef struct packed {
		logic [11:0] nom_std;
		logic [11:0] nom_high;
		logic [11:0] win_std;
		logic [11:0] win_high;
		logic [3:0]  err_limit;
	} rail_cfg_t;

	// one rail check request
	typedef struct packed {
		logic       en;
		logic [2:0] idx;
	} rail_req_t;

	// scan order of the rails
	function automatic chan_t rail_channel(input logic [2:0] idx);
		chan_t ch;
		case (idx)
			3'd0:    ch = 3'd0;
			3'd1:    ch = 3'd1;
			3'd2:    ch = 3'd2;
			3'd3:    ch = 3'd3;
			3'd4:    ch = 3'd7;
			default: ch = 3'd0;
		endcase
		return ch;
	endfunction

	// interlock bit of each rail
	function automatic logic [4:0] rail_bit(input logic [2:0] idx);
		logic [4:0] b;
		case (idx)
			3'd0:    b = 5'h08;
			3'd1:    b = 5'h10;
			3'd2:    b = 5'h01;
			3'd3:    b = 5'h02;
			3'd4:    b = 5'h04;
			default: b = 5'h00;
		endcase
		return b;
	endfunction

	// rail slot of a channel; valid flag in bit 3
	function automatic logic [3:0] rail_index(input logic [3:0] ch);
		logic [3:0] r;
		case (ch)
			4'd0:    r = 4'b1_000;
			4'd1:    r = 4'b1_001;
			4'd2:    r = 4'b1_010;
			4'd3:    r = 4'b1_011;
			4'd7:    r = 4'b1_100;
			default: r = 4'b0_000;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/adcsup_scan_seq.sv
// Scan sequencer: slot counter and position-channel rotation.
module adcsup_scan_seq
	import adcsup_pkg::*;
#(
	parameter int RAIL_COUNT = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic [15:0] scan_period,
	output chan_t       channel
);

	logic [15:0] slot_q;
	chan_t       fptr_q;
	logic [15:0] slot_eff;
	logic        rail_slot;
	chan_t       fptr_eff;

	always_comb begin
		slot_eff  = (slot_q >= scan_period) ? 16'd0 : slot_q;
		rail_slot = slot_eff < 16'(RAIL_COUNT);
		fptr_eff  = (fptr_q inside {[CH_POS_FIRST:CH_POS_LAST]}) ? fptr_q : CH_POS_FIRST;
		channel   = rail_slot ? rail_channel(slot_eff[2:0]) : fptr_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 16'd0;
			fptr_q <= CH_POS_FIRST;
		end else if (advance) begin
			slot_q <= slot_eff + 16'd1;
			if (!rail_slot) begin
				fptr_q <= (fptr_eff >= CH_POS_LAST) ? CH_POS_FIRST : fptr_eff + 3'd1;
			end
		end
	end

endmodule

>>> hw/rtl/adcsup_rail_chk.sv
// Rail window check, bad-sample counters and sticky interlock bits.
module adcsup_rail_chk
	import adcsup_pkg::*;
#(
	parameter int RAIL_COUNT  = 5,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rail_req_t              req,
	input  rail_cfg_t              cfg,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   ok,
	output logic [4:0]             interlock
);

	localparam int CMP_W = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;

	logic [CMP_W-1:0] smp_x;
	logic [CMP_W-1:0] nom_x;
	logic [CMP_W-1:0] win_x;
	logic [CMP_W-1:0] dev;
	logic             high_rail;
	logic [4:0]       interlock_q;
	logic [4:0]       trip_bits;
	logic [4:0]       used_mask;
	logic [RAIL_COUNT-1:0] trip;

	always_comb begin
		high_rail = rail_channel(req.idx) == CH_RAIL_HIGH;
		smp_x     = CMP_W'(sample);
		nom_x     = CMP_W'(high_rail ? cfg.nom_high : cfg.nom_std);
		win_x     = CMP_W'(high_rail ? cfg.win_high : cfg.win_std);
		dev       = (smp_x > nom_x) ? smp_x - nom_x : nom_x - smp_x;
		ok        = !(dev > win_x);
	end

	for (genvar k = 0; k < RAIL_COUNT; k++) begin : g_rail
		logic [3:0] cnt_q;
		logic [4:0] inc;
		logic       hit;

		assign hit     = req.en && (req.idx == 3'(k));
		assign inc     = {1'b0, cnt_q} + 5'd1;
		assign trip[k] = hit && !ok && (inc >= {1'b0, cfg.err_limit});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q <= 4'd0;
			end else if (hit) begin
				if (ok || trip[k]) begin
					cnt_q <= 4'd0;
				end else begin
					cnt_q <= inc[3:0];
				end
			end
		end
	end

	always_comb begin
		trip_bits = 5'd0;
		used_mask = 5'd0;
		for (int k = 0; k < RAIL_COUNT; k++) begin
			used_mask = used_mask | rail_bit(3'(k));
			if (trip[k]) begin
				trip_bits = trip_bits | rail_bit(3'(k));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interlock_q <= 5'd0;
		end else begin
			interlock_q <= interlock_q | trip_bits;
		end
	end

	assign interlock = interlock_q;

	a_interlock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((interlock_q & $past(interlock_q)) == $past(interlock_q)))
		else $error("interlock bit cleared");

	a_unused_rails_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(interlock_q & ~used_mask) == 5'd0)
		else $error("interlock set for a rail that is never scanned");

endmodule

>>> hw/rtl/adc_scan_and_rail_supervisor_top.sv
// Top level of the ADC scan sequencer and supply-rail supervisor.
//
// Usage:
//  - Input channel (sample, sample_valid, sample_stall): one transfer per ADC
//    tick; sample is the conversion of the channel requested on the tick
//    before. Only the low SAMPLE_BITS bits are looked at.
//  - Result channel (result_valid, result_stall): one result per input
//    transfer, in order: the channel to request now, which channel the sample
//    was and how it was used, the rail verdict, sticky interlock bits and the
//    three latched positions.
//  - Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is
//    always high; unknown indexes are dropped. Write only while idle.
// Timing: results are registered and appear in the cycle after the input
// transfer. One item per cycle sustained: all per-tick work (slot compare, one
// subtract and window compare, counter increment) sits between the input edge
// and the result register. When result_stall holds a waiting result,
// sample_stall rises and the next sample waits; a result taken in the same
// cycle frees the register. Reset (arst_n low) restores register defaults,
// clears counters, interlocks and positions, and marks "no previous channel"
// so the first tick checks nothing.
module adc_scan_and_rail_supervisor_top
	import adcsup_pkg::*;
#(
	parameter int RAIL_COUNT  = 5,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// sample channel
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	// result channel
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [2:0]             convert_channel,
	output logic [3:0]             checked_channel,
	output logic [1:0]             checked_kind,
	output logic                   rail_ok,
	output logic [4:0]             power_interlock,
	output logic [11:0]            carrier_position,
	output logic [11:0]            y_jaw_position,
	output logic [11:0]            x_jaw_position,
	// config write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [15:0]            cfg_data
);

	// config registers
	rail_cfg_t   rail_cfg_q;
	logic [15:0] scan_period_q;

	// state
	logic [3:0]  prev_ch_q;      // channel requested on the last tick
	logic [11:0] pos_q [3];

	// result register
	logic        valid_q;
	logic [3:0]  checked_s1;
	kind_t       kind_s1;
	logic        ok_s1;

	logic        accept;
	chan_t       next_ch;
	logic [3:0]  rail_sel;
	logic        prev_is_pos;
	rail_req_t   rail_req;
	logic        rail_ok_c;
	logic [4:0]  interlock;
	kind_t       kind_c;

	assign cfg_ready    = 1'b1;
	assign sample_stall = valid_q && result_stall;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rail_cfg_q.nom_std   <= NOM_STD_RST;
			rail_cfg_q.nom_high  <= NOM_HIGH_RST;
			rail_cfg_q.win_std   <= WIN_STD_RST;
			rail_cfg_q.win_high  <= WIN_HIGH_RST;
			rail_cfg_q.err_limit <= ERR_LIMIT_RST;
			scan_period_q        <= SCAN_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NOM_STD:     rail_cfg_q.nom_std   <= cfg_data[11:0];
				REG_NOM_HIGH:    rail_cfg_q.nom_high  <= cfg_data[11:0];
				REG_WIN_STD:     rail_cfg_q.win_std   <= cfg_data[11:0];
				REG_WIN_HIGH:    rail_cfg_q.win_high  <= cfg_data[11:0];
				REG_ERR_LIMIT:   rail_cfg_q.err_limit <= cfg_data[3:0];
				REG_SCAN_PERIOD: scan_period_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// channel selection for this tick
	adcsup_scan_seq #(
		.RAIL_COUNT(RAIL_COUNT)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.scan_period (scan_period_q),
		.channel     (next_ch)
	);

	// classify the sample by the channel it came from
	always_comb begin
		rail_sel     = rail_index(prev_ch_q);
		prev_is_pos  = prev_ch_q inside {[4'd4:4'd6]};
		rail_req.en  = accept && rail_sel[3];
		rail_req.idx = rail_sel[2:0];
		if (rail_sel[3]) begin
			kind_c = KIND_RAIL;
		end else if (prev_is_pos) begin
			kind_c = KIND_POS;
		end else begin
			kind_c = KIND_NONE;
		end
	end

	adcsup_rail_chk #(
		.RAIL_COUNT  (RAIL_COUNT),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (rail_req),
		.cfg       (rail_cfg_q),
		.sample    (sample),
		.ok        (rail_ok_c),
		.interlock (interlock)
	);

	// previous channel and position latches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ch_q <= NO_CHANNEL;
			pos_q[0]  <= 12'd0;
			pos_q[1]  <= 12'd0;
			pos_q[2]  <= 12'd0;
		end else if (accept) begin
			prev_ch_q <= {1'b0, next_ch};
			case (prev_ch_q)
				4'd4:    pos_q[0] <= 12'(sample);
				4'd5:    pos_q[1] <= 12'(sample);
				4'd6:    pos_q[2] <= 12'(sample);
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			checked_s1 <= (kind_c == KIND_NONE) ? NO_CHANNEL : prev_ch_q;
			kind_s1    <= kind_c;
			ok_s1      <= rail_sel[3] && rail_ok_c;
		end
	end

	// the interlock and position state only moves on a transfer, so it
	// holds steady with the rest of a stalled result
	assign result_valid     = valid_q;
	assign convert_channel  = prev_ch_q[2:0];
	assign checked_channel  = checked_s1;
	assign checked_kind     = kind_s1;
	assign rail_ok          = ok_s1;
	assign power_interlock  = interlock;
	assign carrier_position = pos_q[0];
	assign y_jaw_position   = pos_q[1];
	assign x_jaw_position   = pos_q[2];

	a_none_has_no_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && checked_kind == KIND_NONE) |->
			(checked_channel == NO_CHANNEL && !rail_ok))
		else $error("unchecked sample reports a channel or a verdict");

	a_ok_only_on_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && rail_ok) |-> (checked_kind == KIND_RAIL))
		else $error("rail_ok set on a non-rail sample");

	a_pos_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && checked_kind == KIND_POS) |->
			(checked_channel == 4'd4 || checked_channel == 4'd5 || checked_channel == 4'd6))
		else $error("position latch from a non-position channel");

endmodule

>>> test/adcsup_checker.sv
// Scoreboard for the ADC scan and rail supervisor: predicts each tick and compares results.
module adcsup_checker
	import adcsup_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [11:0] sample,
	input  logic        sample_valid,
	input  logic        sample_stall,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [2:0]  convert_channel,
	input  logic [3:0]  checked_channel,
	input  logic [1:0]  checked_kind,
	input  logic        rail_ok,
	input  logic [4:0]  power_interlock,
	input  logic [11:0] carrier_position,
	input  logic [11:0] y_jaw_position,
	input  logic [11:0] x_jaw_position,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatch_cnt,
	output int          due_cnt,
	output int          checked_cnt
);

	localparam int RAILS = 5;

	typedef struct packed {
		chan_t       conv;
		logic [3:0]  chk;
		kind_t       kind;
		logic        ok;
		logic [4:0]  ilk;
		logic [11:0] carrier;
		logic [11:0] y_jaw;
		logic [11:0] x_jaw;
	} tick_out_t;

	tick_out_t ticks_due[$];

	// register copy
	logic [11:0] nom_std, nom_high, win_std, win_high;
	logic [3:0]  err_lim;
	logic [15:0] period;

	// scan and rail state
	logic [15:0] slot;
	chan_t       fb_ptr;
	logic [3:0]  last_ch;
	logic [3:0]  miss_run [RAILS];
	logic [4:0]  trips;
	logic [11:0] pos_latch [3];

	// rail scan order 0,1,2,3,7
	function automatic chan_t scan_rail(input logic [15:0] k);
		case (k)
			16'd0:   return 3'd0;
			16'd1:   return 3'd1;
			16'd2:   return 3'd2;
			16'd3:   return 3'd3;
			default: return 3'd7;
		endcase
	endfunction

	// position of a channel in the rail list, -1 if not a rail
	function automatic int rail_slot(input logic [3:0] ch);
		case (ch)
			4'd0, 4'd1, 4'd2, 4'd3: return int'(ch);
			4'd7:                   return 4;
			default:                return -1;
		endcase
	endfunction

	function automatic logic [4:0] trip_mask(input int r);
		case (r)
			0:       return 5'h08;
			1:       return 5'h10;
			2:       return 5'h01;
			3:       return 5'h02;
			default: return 5'h04;
		endcase
	endfunction

	task automatic predict_tick(input logic [11:0] smp, output tick_out_t t);
		chan_t       req;
		int          r;
		logic [11:0] nom, win, dev;
		logic [4:0]  run;
		// pick the channel to request on this tick
		if (slot >= period)
			slot = '0;
		if (slot < 16'(RAILS)) begin
			req = scan_rail(slot);
		end else begin
			if (fb_ptr < CH_POS_FIRST || fb_ptr > CH_POS_LAST)
				fb_ptr = CH_POS_FIRST;
			req = fb_ptr;
			fb_ptr = (fb_ptr >= CH_POS_LAST) ? CH_POS_FIRST : fb_ptr + 3'd1;
		end
		slot = slot + 16'd1;

		// use the sample of the channel asked for last tick
		t = '0;
		t.kind = KIND_NONE;
		t.chk = last_ch;
		r = rail_slot(last_ch);
		if (r >= 0) begin
			nom = (last_ch == {1'b0, CH_RAIL_HIGH}) ? nom_high : nom_std;
			win = (last_ch == {1'b0, CH_RAIL_HIGH}) ? win_high : win_std;
			dev = (smp > nom) ? smp - nom : nom - smp;
			t.kind = KIND_RAIL;
			if (dev > win) begin
				run = {1'b0, miss_run[r]} + 5'd1;
				if (run >= {1'b0, err_lim}) begin
					trips = trips | trip_mask(r);
					run = '0;
				end
				miss_run[r] = run[3:0];
			end else begin
				miss_run[r] = '0;
				t.ok = 1'b1;
			end
		end else if (last_ch >= 4'd4 && last_ch <= 4'd6) begin
			t.kind = KIND_POS;
			pos_latch[last_ch[1:0]] = smp;
		end else begin
			t.chk = NO_CHANNEL;
		end
		last_ch = {1'b0, req};

		t.conv = req;
		t.ilk = trips;
		t.carrier = pos_latch[0];
		t.y_jaw = pos_latch[1];
		t.x_jaw = pos_latch[2];
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		tick_out_t want, got;
		if (!arst_n) begin
			nom_std = NOM_STD_RST;
			nom_high = NOM_HIGH_RST;
			win_std = WIN_STD_RST;
			win_high = WIN_HIGH_RST;
			err_lim = ERR_LIMIT_RST;
			period = SCAN_PERIOD_RST;
			slot = '0;
			fb_ptr = CH_POS_FIRST;
			last_ch = NO_CHANNEL;
			for (int i = 0; i < RAILS; i++)
				miss_run[i] = '0;
			trips = '0;
			for (int i = 0; i < 3; i++)
				pos_latch[i] = '0;
			ticks_due.delete();
			mismatch_cnt = 0;
			checked_cnt = 0;
			due_cnt <= 0;
		end else begin
			// result side first: a transfer here belongs to an earlier sample
			if (result_valid && !result_stall) begin
				got.conv = convert_channel;
				got.chk = checked_channel;
				got.kind = kind_t'(checked_kind);
				got.ok = rail_ok;
				got.ilk = power_interlock;
				got.carrier = carrier_position;
				got.y_jaw = y_jaw_position;
				got.x_jaw = x_jaw_position;
				if (ticks_due.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("result %0d arrived with nothing outstanding", checked_cnt);
				end else begin
					want = ticks_due.pop_front();
					if (got !== want) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("result %0d mismatch: exp ch=%0d chk=%0d kind=%0d ok=%0b ilk=%b pos=%h,%h,%h",
								checked_cnt, want.conv, want.chk, want.kind, want.ok, want.ilk,
								want.carrier, want.y_jaw, want.x_jaw);
							$display("    got ch=%0d chk=%0d kind=%0d ok=%0b ilk=%b pos=%h,%h,%h",
								got.conv, got.chk, got.kind, got.ok, got.ilk,
								got.carrier, got.y_jaw, got.x_jaw);
						end
					end
				end
				checked_cnt++;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_NOM_STD:     nom_std = cfg_data[11:0];
					REG_NOM_HIGH:    nom_high = cfg_data[11:0];
					REG_WIN_STD:     win_std = cfg_data[11:0];
					REG_WIN_HIGH:    win_high = cfg_data[11:0];
					REG_ERR_LIMIT:   err_lim = cfg_data[3:0];
					REG_SCAN_PERIOD: period = cfg_data;
					default: ;
				endcase
			end

			if (sample_valid && !sample_stall) begin
				predict_tick(sample, want);
				ticks_due.push_back(want);
			end
			due_cnt <= ticks_due.size();
		end
	end

endmodule

>>> test/tb_top.sv
// Top of the ADC scan and rail supervisor testbench: clock, reset, stimulus and verdict.
module tb_top;
	import adcsup_pkg::*;

	// quiet cycles (no transfer on any channel) before the run is declared hung;
	// the longest legit quiet stretch is the receiver hold below
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 200;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 120;

	// indexes past the register list; writes to them must be dropped
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	logic        clk;
	logic        arst_n;
	logic [11:0] sample;
	logic        sample_valid;
	logic        sample_stall;
	logic        result_valid;
	logic        result_stall;
	logic [2:0]  convert_channel;
	logic [3:0]  checked_channel;
	logic [1:0]  checked_kind;
	logic        rail_ok;
	logic [4:0]  power_interlock;
	logic [11:0] carrier_position;
	logic [11:0] y_jaw_position;
	logic [11:0] x_jaw_position;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	int mismatch_cnt;
	int due_cnt;
	int checked_cnt;

	// shared between the sample side and the result side
	bit gaps_on  = 1'b1;
	bit hold_req = 1'b0;

	// what the stimulus believes is loaded; only used to aim samples at windows
	int cur_nom_std  = 3072;
	int cur_nom_high = 3277;
	int cur_win_std  = 307;
	int cur_win_high = 328;

	int items_sent = 0;
	int setups     = 0;
	int quiet      = 0;

	adc_scan_and_rail_supervisor_top uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample           (sample),
		.sample_valid     (sample_valid),
		.sample_stall     (sample_stall),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.convert_channel  (convert_channel),
		.checked_channel  (checked_channel),
		.checked_kind     (checked_kind),
		.rail_ok          (rail_ok),
		.power_interlock  (power_interlock),
		.carrier_position (carrier_position),
		.y_jaw_position   (y_jaw_position),
		.x_jaw_position   (x_jaw_position),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	adcsup_checker chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample           (sample),
		.sample_valid     (sample_valid),
		.sample_stall     (sample_stall),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.convert_channel  (convert_channel),
		.checked_channel  (checked_channel),
		.checked_kind     (checked_kind),
		.rail_ok          (rail_ok),
		.power_interlock  (power_interlock),
		.carrier_position (carrier_position),
		.y_jaw_position   (y_jaw_position),
		.x_jaw_position   (x_jaw_position),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mismatch_cnt     (mismatch_cnt),
		.due_cnt          (due_cnt),
		.checked_cnt      (checked_cnt)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// hang detector: any transfer on any channel restarts the count
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("no transfer for %0d cycles", QUIET_LIMIT);
			$display("FAIL adc_scan_and_rail_supervisor_top");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Result side. Per transfer it may hold stall at random, then drops it and
	// waits for the transfer. A hold request from the stimulus parks it for a long
	// stretch so the single result register fills and sample_stall backs up.
	initial begin : result_side
		int hold_gap;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end
			hold_gap = gaps_on ? $urandom_range(7, 0) : 0;
			if (hold_gap > 0) begin
				result_stall <= 1'b1;
				repeat (hold_gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	// One sample transfer with an optional idle gap in front. Valid stays high
	// across back-to-back transfers, so no drop-and-raise within a step.
	task automatic send_sample(input logic [11:0] v);
		int gap;
		gap = gaps_on ? $urandom_range(7, 0) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample <= v;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!(sample_valid && !sample_stall));
		items_sent++;
	endtask

	// Stop offering samples and wait until every outstanding result is taken.
	// Every tick yields a result, so an empty scoreboard means the block is idle.
	task automatic settle();
		sample_valid <= 1'b0;
		do @(posedge clk); while (due_cnt != 0);
	endtask

	// cfg_valid is left high; the caller drops it after the last write
	task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
	endtask

	// Full register load while idle. Unused upper data bits carry junk that the
	// block must ignore, and one spare index is hit every time.
	task automatic load_regs(input logic [11:0] ns, input logic [11:0] nh,
			input logic [11:0] ws, input logic [11:0] wh,
			input logic [3:0] lim, input logic [15:0] per);
		logic [3:0]  junk4;
		logic [11:0] junk12;
		settle();
		junk4 = 4'($urandom_range(15, 0));
		cfg_write(REG_NOM_STD, {junk4, ns});
		junk4 = 4'($urandom_range(15, 0));
		cfg_write(REG_NOM_HIGH, {junk4, nh});
		junk4 = 4'($urandom_range(15, 0));
		cfg_write(REG_WIN_STD, {junk4, ws});
		junk4 = 4'($urandom_range(15, 0));
		cfg_write(REG_WIN_HIGH, {junk4, wh});
		junk12 = 12'($urandom_range(4095, 0));
		cfg_write(REG_ERR_LIMIT, {junk12, lim});
		cfg_write(REG_SCAN_PERIOD, per);
		cfg_write($urandom_range(1, 0) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
		cfg_valid <= 1'b0;
		cur_nom_std = int'(ns);
		cur_nom_high = int'(nh);
		cur_win_std = int'(ws);
		cur_win_high = int'(wh);
		setups++;
	endtask

	// Aim near one of the two nominal codes, inside or just outside the window;
	// a slice of fully random codes keeps every sample bit moving.
	function automatic logic [11:0] pick_sample(input int bad_pct);
		int pick, nom, win, v;
		pick = $urandom_range(99, 0);
		if (pick < 15)
			return 12'($urandom_range(4095, 0));
		if (pick < 35) begin
			nom = cur_nom_high;
			win = cur_win_high;
		end else begin
			nom = cur_nom_std;
			win = cur_win_std;
		end
		if ($urandom_range(99, 0) < bad_pct)
			v = win + 1 + $urandom_range(40, 0);
		else
			v = $urandom_range(win, 0);
		v = $urandom_range(1, 0) ? nom + v : nom - v;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[11:0];
	endfunction

	initial begin : stimulus
		logic [11:0] ns, nh, ws, wh;
		logic [3:0]  lim;
		logic [15:0] per;
		int          bad_pct;

		arst_n = 1'b0;
		sample = '0;
		sample_valid = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings. Tick 0 has no previous channel, then the
		// rails come in scan order 0,1,2,3,7 and the position rotation follows.
		send_sample(12'hFFF);           // nothing checked yet
		send_sample(12'h000);           // rail 0 far below nominal
		send_sample(12'hFFF);           // rail 1 far above nominal
		send_sample(12'd3072);          // rail 2 right on nominal
		send_sample(12'd3379);          // rail 3 at the top edge of the window
		send_sample(12'd2764);          // rail 7 one code past the bottom edge
		send_sample(12'hFFF);           // carrier
		send_sample(12'h000);           // y jaw
		send_sample(12'hAAA);           // x jaw
		send_sample(12'h555);           // carrier again

		// Period lowered below the current slot: the scan restarts at rail 0.
		load_regs(12'd3072, 12'd3277, 12'd307, 12'd328, 4'd3, 16'd6);
		send_sample(12'h123);           // y jaw latch
		send_sample(12'd3072);          // rail 0 good, clears its count
		send_sample(12'd3605);          // rail 1 at the top edge of its window
		send_sample(12'd2765);          // rail 2 at the bottom edge
		send_sample(12'hFFF);           // rail 3 bad
		send_sample(12'd3072);          // rail 7 good
		send_sample(12'h876);           // first feedback slot

		// Period zero and limit zero: rail 0 every tick, each bad sample trips.
		load_regs(12'd3072, 12'd3277, 12'd307, 12'd328, 4'd0, 16'd0);
		send_sample(12'h321);
		send_sample(12'd3072);
		send_sample(12'h000);
		send_sample(12'hFFF);

		// Two corner phases, then random ones. Early random ones keep limits high and
		// samples mostly in the window so trips come late; later ones get harsher.
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0) begin
				// everything at its top value
				ns = 12'hFFF; nh = 12'hFFF; ws = 12'hFFF; wh = 12'hFFF;
				lim = 4'hF; per = 16'hFFFF;
			end else if (phase == 1) begin
				// everything at zero
				ns = '0; nh = '0; ws = '0; wh = '0; lim = '0; per = '0;
			end else begin
				ns = 12'($urandom_range(4095, 0));
				nh = 12'($urandom_range(4095, 0));
				ws = 12'($urandom_range(400, 0));
				wh = 12'($urandom_range(400, 0));
				lim = (phase < 6) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(15, 0));
				case ($urandom_range(4, 0))
					0:       per = 16'($urandom_range(6, 0));      // restart each tick, rails only, or one feedback slot
					1, 2:    per = 16'($urandom_range(30, 7));
					3:       per = 16'($urandom_range(200, 31));
					default: per = 16'hFFFF;
				endcase
			end
			load_regs(ns, nh, ws, wh, lim, per);
			bad_pct = 10 + 7 * phase;
			// every third phase runs without any idling on either side
			gaps_on = (phase % 3) != 2;

			// back-to-back samples against a parked receiver
			if (phase == 4) begin
				gaps_on = 1'b0;
				hold_req = 1'b1;
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 4 && n == 40)
					gaps_on = 1'b1;
				// sender waits out every result mid-stream once
				if (phase == 7 && n == 60)
					settle();
				send_sample(pick_sample(bad_pct));
			end
		end

		// drain, then wait for anything stray to show up
		settle();
		repeat (4) @(posedge clk);

		$display("covered %0d samples under %0d register loads, %0d results compared",
			items_sent, setups, checked_cnt);
		$display("final interlock bits %b, mismatches %0d", power_interlock, mismatch_cnt);
		if (mismatch_cnt == 0 && due_cnt == 0)
			$display("PASS adc_scan_and_rail_supervisor_top");
		else
			$display("FAIL adc_scan_and_rail_supervisor_top");
		$finish;
	end

endmodule
